[hdl/hybrid_branch_predictor_top_macros.svh]
// Assertion helpers for the branch predictor.
// All checks sample on clk_i and are off while rst_ni is low.
`ifndef HYBRID_BRANCH_PREDICTOR_TOP_MACROS_SVH
`define HYBRID_BRANCH_PREDICTOR_TOP_MACROS_SVH

// Same-cycle implication
`define HBP_ASSERT_SAME(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication
`define HBP_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

// Invariant
`define HBP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`endif

[hdl/hbp_pkg.sv]
package hbp_pkg;

  // Default table sizes and address width
  localparam int DEF_MAX_BIMODAL_BITS = 14;
  localparam int DEF_MAX_GSHARE_BITS  = 14;
  localparam int DEF_MAX_CHOOSER_BITS = 14;
  localparam int DEF_PC_WIDTH         = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE         = 3'd0,
    CFG_CHOOSER_BITS = 3'd1,
    CFG_GSHARE_BITS  = 3'd2,
    CFG_HISTORY_BITS = 3'd3,
    CFG_BIMODAL_BITS = 3'd4
  } cfg_idx_e;

  // Predictor mode; the unused code behaves as hybrid
  typedef enum logic [1:0] {
    MODE_BIMODAL = 2'd0,
    MODE_GSHARE  = 2'd1,
    MODE_HYBRID  = 2'd2
  } mode_e;

  // Configuration reset values
  localparam logic [1:0]            RST_MODE         = MODE_HYBRID;
  localparam logic [CFG_DATA_W-1:0] RST_CHOOSER_BITS = 4'd8;
  localparam logic [CFG_DATA_W-1:0] RST_GSHARE_BITS  = 4'd14;
  localparam logic [CFG_DATA_W-1:0] RST_HISTORY_BITS = 4'd8;
  localparam logic [CFG_DATA_W-1:0] RST_BIMODAL_BITS = 4'd14;

  // 2-bit saturating counter values
  typedef logic [1:0] cnt_t;
  localparam cnt_t CNT_MIN        = 2'd0;
  localparam cnt_t CNT_WEAK_NOT   = 2'd1;
  localparam cnt_t CNT_WEAK_TAKEN = 2'd2;
  localparam cnt_t CNT_MAX        = 2'd3;

  function automatic cnt_t sat_step(cnt_t c, logic up);
    if (up) begin
      return (c == CNT_MAX) ? c : c + 2'd1;
    end
    return (c == CNT_MIN) ? c : c - 2'd1;
  endfunction

endpackage

[hdl/hybrid_branch_predictor_top.sv]
// Hybrid bimodal / gshare branch predictor. Each item is one resolved branch (address and
// outcome); the block returns the prediction made before the update, a mispredict flag and
// saturating 32-bit counts of branches and misses. It sustains one item per clock once the
// clearing pass is over and while results are taken: the three counter tables are single-port-
// write synchronous RAMs read when an item is accepted and written back when it leaves stage
// 1, with a one-entry bypass per table covering back-to-back branches to the same entry. A
// result is loaded into the output register when its item leaves stage 1, and that register
// lets a new item enter while a result waits. After reset a clearing pass writes the reset
// values into every table entry; no item is taken during it, though configuration writes
// are. The configuration port is always ready.
`include "hybrid_branch_predictor_top_macros.svh"

module hybrid_branch_predictor_top
  import hbp_pkg::*;
#(
  parameter int MAX_BIMODAL_BITS = DEF_MAX_BIMODAL_BITS,
  parameter int MAX_GSHARE_BITS  = DEF_MAX_GSHARE_BITS,
  parameter int MAX_CHOOSER_BITS = DEF_MAX_CHOOSER_BITS,
  parameter int PC_WIDTH         = DEF_PC_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // resolved branches
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PC_WIDTH-1:0]   branch_pc_i,
  input  logic                  taken_i,
  // results
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  predicted_taken_o,
  output logic                  mispredicted_o,
  output logic [31:0]           branches_seen_o,
  output logic [31:0]           misses_seen_o
);

  localparam int BIM_W  = MAX_BIMODAL_BITS;
  localparam int GSH_W  = MAX_GSHARE_BITS;
  localparam int CHO_W  = MAX_CHOOSER_BITS;
  localparam int BIM_SW = $clog2(MAX_BIMODAL_BITS + 1);
  localparam int GSH_SW = $clog2(MAX_GSHARE_BITS + 1);
  localparam int CHO_SW = $clog2(MAX_CHOOSER_BITS + 1);
  localparam int WORD_W = PC_WIDTH - 2;
  localparam int BG_W   = (BIM_W > GSH_W) ? BIM_W : GSH_W;
  localparam int TBL_W  = (BG_W > CHO_W) ? BG_W : CHO_W;
  localparam int EXT_W  = (WORD_W > TBL_W) ? WORD_W : TBL_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [1:0]            mode_q;
  logic [CFG_DATA_W-1:0] cho_bits_q, gsh_bits_q, hist_bits_q, bim_bits_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= RST_MODE;
      cho_bits_q  <= RST_CHOOSER_BITS;
      gsh_bits_q  <= RST_GSHARE_BITS;
      hist_bits_q <= RST_HISTORY_BITS;
      bim_bits_q  <= RST_BIMODAL_BITS;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_MODE:         mode_q      <= cfg_data_i[1:0];
        CFG_CHOOSER_BITS: cho_bits_q  <= cfg_data_i;
        CFG_GSHARE_BITS:  gsh_bits_q  <= cfg_data_i;
        CFG_HISTORY_BITS: hist_bits_q <= cfg_data_i;
        CFG_BIMODAL_BITS: bim_bits_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake and pipeline control
  // ---------------------------------------------------------------------------
  logic clr_active_q;
  logic s1_valid_q, out_valid_q;
  logic s1_adv, s1_fire, in_acc;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && s1_adv;
  assign in_stall_o = clr_active_q || (s1_valid_q && !s1_adv);
  assign in_acc     = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------------
  // Index widths, clamped to 1..MAX
  // ---------------------------------------------------------------------------
  logic [BIM_SW-1:0] m2;
  logic [GSH_SW-1:0] m1, hn, hshift;
  logic [CHO_SW-1:0] kb;

  always_comb begin
    if (bim_bits_q == '0) begin
      m2 = BIM_SW'(1);
    end else if (int'(bim_bits_q) > MAX_BIMODAL_BITS) begin
      m2 = BIM_SW'(MAX_BIMODAL_BITS);
    end else begin
      m2 = BIM_SW'(bim_bits_q);
    end

    if (gsh_bits_q == '0) begin
      m1 = GSH_SW'(1);
    end else if (int'(gsh_bits_q) > MAX_GSHARE_BITS) begin
      m1 = GSH_SW'(MAX_GSHARE_BITS);
    end else begin
      m1 = GSH_SW'(gsh_bits_q);
    end

    if (cho_bits_q == '0) begin
      kb = CHO_SW'(1);
    end else if (int'(cho_bits_q) > MAX_CHOOSER_BITS) begin
      kb = CHO_SW'(MAX_CHOOSER_BITS);
    end else begin
      kb = CHO_SW'(cho_bits_q);
    end

    // history never longer than the gshare index
    hn     = (int'(hist_bits_q) > int'(m1)) ? m1 : GSH_SW'(hist_bits_q);
    hshift = m1 - hn;
  end

  // ---------------------------------------------------------------------------
  // Table indexes and history update at acceptance
  // ---------------------------------------------------------------------------
  logic [EXT_W-1:0] word_ext;
  logic [BIM_W-1:0] bim_mask, bidx;
  logic [GSH_W-1:0] gsh_mask, hist_mask, hist, gidx, ghist_q, ghist_new;
  logic [CHO_W-1:0] cho_mask, cidx;

  always_comb begin
    word_ext  = EXT_W'(branch_pc_i[PC_WIDTH-1:2]);
    bim_mask  = ~({BIM_W{1'b1}} << m2);
    gsh_mask  = ~({GSH_W{1'b1}} << m1);
    cho_mask  = ~({CHO_W{1'b1}} << kb);
    hist_mask = ~({GSH_W{1'b1}} << hn);
    hist      = ghist_q & hist_mask;
    bidx      = word_ext[BIM_W-1:0] & bim_mask;
    gidx      = (word_ext[GSH_W-1:0] & gsh_mask) ^ ((hist << hshift) & gsh_mask);
    cidx      = word_ext[CHO_W-1:0] & cho_mask;
    if (hn == '0) begin
      ghist_new = '0;
    end else begin
      ghist_new = (hist >> 1) | (GSH_W'(taken_i) << (hn - GSH_SW'(1)));
    end
  end

  // history only depends on the outcome, so it moves at acceptance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ghist_q <= '0;
    end else if (in_acc && (mode_q != MODE_BIMODAL)) begin
      ghist_q <= ghist_new;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 registers: item waiting on table read data
  // ---------------------------------------------------------------------------
  logic [BIM_W-1:0] s1_bidx_q;
  logic [GSH_W-1:0] s1_gidx_q;
  logic [CHO_W-1:0] s1_cidx_q;
  logic             s1_taken_q;
  logic [1:0]       s1_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_bidx_q  <= bidx;
      s1_gidx_q  <= gidx;
      s1_cidx_q  <= cidx;
      s1_taken_q <= taken_i;
      s1_mode_q  <= mode_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Clearing pass after reset
  // ---------------------------------------------------------------------------
  logic [TBL_W-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else if (clr_active_q) begin
      clr_addr_q <= clr_addr_q + TBL_W'(1);
      if (clr_addr_q == {TBL_W{1'b1}}) begin
        clr_active_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Counter tables
  // ---------------------------------------------------------------------------
  cnt_t bim_mem [2**BIM_W];
  cnt_t gsh_mem [2**GSH_W];
  cnt_t cho_mem [2**CHO_W];
  cnt_t bim_rd_q, gsh_rd_q, cho_rd_q;

  logic             bim_we, gsh_we, cho_we;
  logic [BIM_W-1:0] bim_waddr;
  logic [GSH_W-1:0] gsh_waddr;
  logic [CHO_W-1:0] cho_waddr;
  cnt_t             bim_wdata, gsh_wdata, cho_wdata;

  always_ff @(posedge clk_i) begin
    if (bim_we) begin
      bim_mem[bim_waddr] <= bim_wdata;
    end
    if (in_acc) begin
      bim_rd_q <= bim_mem[bidx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (gsh_we) begin
      gsh_mem[gsh_waddr] <= gsh_wdata;
    end
    if (in_acc) begin
      gsh_rd_q <= gsh_mem[gidx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cho_we) begin
      cho_mem[cho_waddr] <= cho_wdata;
    end
    if (in_acc) begin
      cho_rd_q <= cho_mem[cidx];
    end
  end

  // ---------------------------------------------------------------------------
  // Bypass of the last write into each table
  // ---------------------------------------------------------------------------
  logic             fwd_bim_v_q, fwd_gsh_v_q, fwd_cho_v_q;
  logic [BIM_W-1:0] fwd_bim_addr_q;
  logic [GSH_W-1:0] fwd_gsh_addr_q;
  logic [CHO_W-1:0] fwd_cho_addr_q;
  cnt_t             fwd_bim_data_q, fwd_gsh_data_q, fwd_cho_data_q;
  cnt_t             bim_cnt, gsh_cnt, cho_cnt;

  assign bim_cnt = (fwd_bim_v_q && (fwd_bim_addr_q == s1_bidx_q)) ? fwd_bim_data_q : bim_rd_q;
  assign gsh_cnt = (fwd_gsh_v_q && (fwd_gsh_addr_q == s1_gidx_q)) ? fwd_gsh_data_q : gsh_rd_q;
  assign cho_cnt = (fwd_cho_v_q && (fwd_cho_addr_q == s1_cidx_q)) ? fwd_cho_data_q : cho_rd_q;

  // ---------------------------------------------------------------------------
  // Prediction and update
  // ---------------------------------------------------------------------------
  logic use_gsh, hybrid, bim_ok, gsh_ok, pred, miss;
  logic s1_bim_we, s1_gsh_we, s1_cho_we;

  always_comb begin
    unique case (s1_mode_q)
      MODE_BIMODAL: begin
        use_gsh = 1'b0;
        hybrid  = 1'b0;
      end
      MODE_GSHARE: begin
        use_gsh = 1'b1;
        hybrid  = 1'b0;
      end
      default: begin
        use_gsh = cho_cnt[1];
        hybrid  = 1'b1;
      end
    endcase
    bim_ok    = (bim_cnt[1] == s1_taken_q);
    gsh_ok    = (gsh_cnt[1] == s1_taken_q);
    pred      = use_gsh ? gsh_cnt[1] : bim_cnt[1];
    miss      = (pred != s1_taken_q);
    s1_bim_we = s1_fire && !use_gsh;
    s1_gsh_we = s1_fire && use_gsh;
    // chooser moves only when exactly one predictor was right
    s1_cho_we = s1_fire && hybrid && (gsh_ok != bim_ok);
  end

  // memory write ports: clearing pass or stage 1 writeback
  always_comb begin
    bim_we    = clr_active_q || s1_bim_we;
    gsh_we    = clr_active_q || s1_gsh_we;
    cho_we    = clr_active_q || s1_cho_we;
    bim_waddr = clr_active_q ? clr_addr_q[BIM_W-1:0] : s1_bidx_q;
    gsh_waddr = clr_active_q ? clr_addr_q[GSH_W-1:0] : s1_gidx_q;
    cho_waddr = clr_active_q ? clr_addr_q[CHO_W-1:0] : s1_cidx_q;
    bim_wdata = clr_active_q ? CNT_WEAK_TAKEN : sat_step(bim_cnt, s1_taken_q);
    gsh_wdata = clr_active_q ? CNT_WEAK_TAKEN : sat_step(gsh_cnt, s1_taken_q);
    cho_wdata = clr_active_q ? CNT_WEAK_NOT : sat_step(cho_cnt, gsh_ok);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_bim_v_q <= 1'b0;
      fwd_gsh_v_q <= 1'b0;
      fwd_cho_v_q <= 1'b0;
    end else begin
      if (s1_bim_we) fwd_bim_v_q <= 1'b1;
      if (s1_gsh_we) fwd_gsh_v_q <= 1'b1;
      if (s1_cho_we) fwd_cho_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_bim_we) begin
      fwd_bim_addr_q <= s1_bidx_q;
      fwd_bim_data_q <= bim_wdata;
    end
    if (s1_gsh_we) begin
      fwd_gsh_addr_q <= s1_gidx_q;
      fwd_gsh_data_q <= gsh_wdata;
    end
    if (s1_cho_we) begin
      fwd_cho_addr_q <= s1_cidx_q;
      fwd_cho_data_q <= cho_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Running counts and output register
  // ---------------------------------------------------------------------------
  logic [31:0] pred_total_q, pred_total_d, miss_total_q, miss_total_d;
  logic        pred_q, miss_q;

  always_comb begin
    pred_total_d = (pred_total_q == '1) ? pred_total_q : pred_total_q + 32'd1;
    miss_total_d = (!miss || (miss_total_q == '1)) ? miss_total_q : miss_total_q + 32'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_total_q <= '0;
      miss_total_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (s1_fire) begin
        pred_total_q <= pred_total_d;
        miss_total_q <= miss_total_d;
        out_valid_q  <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      pred_q <= pred;
      miss_q <= miss;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign predicted_taken_o = pred_q;
  assign mispredicted_o    = miss_q;
  assign branches_seen_o   = pred_total_q;
  assign misses_seen_o     = miss_total_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `HBP_ASSERT_NEXT(a_accept_fills_s1, in_acc, s1_valid_q, "accepted item missing from stage 1")
  `HBP_ASSERT_NEXT(a_stalled_counts_hold, out_valid_q && out_stall_i,
                   out_valid_q && $stable(pred_total_q) && $stable(miss_total_q),
                   "counts moved under a stalled result")
  `HBP_ASSERT_ALWAYS(a_miss_le_total, miss_total_q <= pred_total_q,
                     "miss count above branch count")
  `HBP_ASSERT_SAME(a_clear_complete, $fell(clr_active_q),
                   $past(clr_addr_q) == {TBL_W{1'b1}}, "clearing pass ended early")
  `HBP_ASSERT_SAME(a_miss_counted, out_valid_q && miss_q, miss_total_q != 32'd0,
                   "mispredict flagged but not counted")

endmodule

[tb/hybrid_branch_predictor_top_test.sv]
module hybrid_branch_predictor_top_test;
  import hbp_pkg::*;

  localparam int BIM_DEPTH = 1 << DEF_MAX_BIMODAL_BITS;
  localparam int GSH_DEPTH = 1 << DEF_MAX_GSHARE_BITS;
  localparam int CHO_DEPTH = 1 << DEF_MAX_CHOOSER_BITS;

  // 2-bit counter levels
  localparam logic [1:0] CTR_MIN        = 2'd0;
  localparam logic [1:0] CTR_WEAK_NOT   = 2'd1;
  localparam logic [1:0] CTR_WEAK_TAKEN = 2'd2;
  localparam logic [1:0] CTR_MAX        = 2'd3;

  // unused mode code, behaves as hybrid
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // branch behaviors of the hot branch pool
  localparam int KIND_TAKEN  = 0;
  localparam int KIND_NOT    = 1;
  localparam int KIND_ALT    = 2;
  localparam int KIND_LOOP   = 3;
  localparam int KIND_FOLLOW = 4;
  localparam int KIND_COUNT  = 5;
  localparam int HOT_COUNT   = 12;

  // run plan: phase 0 runs on reset values, later phases rewrite every register
  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 110;
  localparam int DRAIN_PHASE  = 4;
  localparam int DRAIN_ITEM   = 50;
  localparam int BACKLOG_AT   = 60;
  localparam int BACKLOG_LEN  = 300;
  localparam int SETTLE_CYCLES = 8;

  localparam logic [1:0] PLAN_MODE [PHASES] = '{MODE_HYBRID, MODE_BIMODAL, MODE_GSHARE,
    MODE_HYBRID, MODE_SPARE, MODE_GSHARE, MODE_HYBRID, MODE_HYBRID, MODE_BIMODAL};
  localparam logic [3:0] PLAN_CHO [PHASES] = '{4'd8, 4'd1, 4'd9, 4'd14, 4'd0, 4'd5, 4'd4,
    4'd15, 4'd8};
  localparam logic [3:0] PLAN_GSH [PHASES] = '{4'd14, 4'd14, 4'd15, 4'd4, 4'd1, 4'd6, 4'd10,
    4'd0, 4'd14};
  localparam logic [3:0] PLAN_HIST [PHASES] = '{4'd8, 4'd14, 4'd15, 4'd14, 4'd0, 4'd3,
    4'd10, 4'd1, 4'd8};
  localparam logic [3:0] PLAN_BIM [PHASES] = '{4'd14, 4'd0, 4'd3, 4'd15, 4'd1, 4'd7, 4'd5,
    4'd14, 4'd14};

  typedef struct packed {
    logic [31:0] pc;
    logic        taken;
    logic        hold_for_drain;
  } branch_t;

  typedef struct packed {
    logic        predicted;
    logic        miss;
    logic [31:0] branches;
    logic [31:0] misses;
  } outcome_t;

  // DUT ports
  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [31:0]           branch_pc_i = '0;
  logic                  taken_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  predicted_taken_o;
  logic                  mispredicted_o;
  logic [31:0]           branches_seen_o;
  logic [31:0]           misses_seen_o;

  // predictor copy: registers and state
  logic [1:0]  mode_q;
  logic [3:0]  cho_bits_q, gsh_bits_q, hist_bits_q, bim_bits_q;
  logic [1:0]  bim_ctr [BIM_DEPTH];
  logic [1:0]  gsh_ctr [GSH_DEPTH];
  logic [1:0]  cho_ctr [CHO_DEPTH];
  logic [13:0] ghist;
  logic [31:0] branch_total, miss_total;

  // stimulus and scoreboard
  branch_t     pending_branches[$];
  outcome_t    expected_outcomes[$];
  int          n_accepted = 0;
  int          n_checked = 0;
  int          fail_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned backlog_left = 0;
  logic        backlog_done = 1'b0;

  // hot branch pool
  logic [31:0] hot_pc [HOT_COUNT];
  int unsigned hot_visits [HOT_COUNT];
  logic        last_outcome = 1'b0;

  hybrid_branch_predictor_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .branch_pc_i      (branch_pc_i),
    .taken_i          (taken_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .predicted_taken_o(predicted_taken_o),
    .mispredicted_o   (mispredicted_o),
    .branches_seen_o  (branches_seen_o),
    .misses_seen_o    (misses_seen_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // index width as used: zero counts as one, clamp to table size
  function automatic int unsigned eff_bits(logic [3:0] b, int unsigned maxb);
    if (b == 4'd0) return 1;
    if (b > maxb) return maxb;
    return b;
  endfunction

  function automatic logic [1:0] counter_next(logic [1:0] c, logic up);
    if (up) return (c == CTR_MAX) ? c : c + 2'd1;
    return (c == CTR_MIN) ? c : c - 2'd1;
  endfunction

  function automatic void reset_predictor();
    mode_q      = MODE_HYBRID;
    cho_bits_q  = 4'd8;
    gsh_bits_q  = 4'd14;
    hist_bits_q = 4'd8;
    bim_bits_q  = 4'd14;
    foreach (bim_ctr[i]) bim_ctr[i] = CTR_WEAK_TAKEN;
    foreach (gsh_ctr[i]) gsh_ctr[i] = CTR_WEAK_TAKEN;
    foreach (cho_ctr[i]) cho_ctr[i] = CTR_WEAK_NOT;
    ghist        = '0;
    branch_total = '0;
    miss_total   = '0;
  endfunction

  // predict one resolved branch, then train the tables as the block does
  function automatic outcome_t resolve_branch(logic [31:0] pc, logic tk);
    outcome_t    o;
    logic [31:0] word, bidx, gidx, cidx, hist;
    int unsigned m1, m2, k, n;
    logic        bim_hit, gsh_hit, use_gsh, pick;
    word = {2'b00, pc[31:2]};
    m2 = eff_bits(bim_bits_q, DEF_MAX_BIMODAL_BITS);
    m1 = eff_bits(gsh_bits_q, DEF_MAX_GSHARE_BITS);
    k  = eff_bits(cho_bits_q, DEF_MAX_CHOOSER_BITS);
    n  = hist_bits_q;
    if (n > m1) n = m1;
    bidx = word & ((32'd1 << m2) - 32'd1);
    hist = {18'd0, ghist} & ((32'd1 << n) - 32'd1);
    gidx = (word ^ (hist << (m1 - n))) & ((32'd1 << m1) - 32'd1);
    cidx = word & ((32'd1 << k) - 32'd1);
    bim_hit = bim_ctr[bidx] >= CTR_WEAK_TAKEN;
    gsh_hit = gsh_ctr[gidx] >= CTR_WEAK_TAKEN;
    case (mode_q)
      MODE_BIMODAL: begin
        use_gsh = 1'b0;
        pick    = bim_hit;
      end
      MODE_GSHARE: begin
        use_gsh = 1'b1;
        pick    = gsh_hit;
      end
      default: begin
        use_gsh = cho_ctr[cidx] >= CTR_WEAK_TAKEN;
        pick    = use_gsh ? gsh_hit : bim_hit;
        // chooser moves only when exactly one side was right
        if (gsh_hit == tk && bim_hit != tk) cho_ctr[cidx] = counter_next(cho_ctr[cidx], 1'b1);
        else if (gsh_hit != tk && bim_hit == tk)
          cho_ctr[cidx] = counter_next(cho_ctr[cidx], 1'b0);
      end
    endcase
    if (use_gsh) gsh_ctr[gidx] = counter_next(gsh_ctr[gidx], tk);
    else bim_ctr[bidx] = counter_next(bim_ctr[bidx], tk);
    // history shifts right, new outcome enters at bit n-1
    if (mode_q != MODE_BIMODAL) begin
      if (n == 0) ghist = '0;
      else ghist = 14'((hist >> 1) | (32'(tk) << (n - 1)));
    end
    if (branch_total != '1) branch_total = branch_total + 32'd1;
    if (pick != tk && miss_total != '1) miss_total = miss_total + 32'd1;
    o.predicted = pick;
    o.miss      = pick != tk;
    o.branches  = branch_total;
    o.misses    = miss_total;
    return o;
  endfunction

  function automatic void queue_branch(logic [31:0] pc, logic tk);
    branch_t b;
    b.pc = pc;
    b.taken = tk;
    b.hold_for_drain = 1'b0;
    pending_branches.push_back(b);
  endfunction

  // mostly trainable branches from a hot pool, some fully random ones
  function automatic branch_t make_branch();
    branch_t     b;
    int unsigned h, r;
    r = $urandom_range(99);
    b.hold_for_drain = 1'b0;
    if (r < 20) begin
      b.pc    = $urandom;
      b.taken = 1'($urandom_range(1));
    end else begin
      h = $urandom_range(HOT_COUNT - 1);
      b.pc = hot_pc[h];
      // alias: same low index bits, different upper address
      if (r < 28) b.pc[31:16] = 16'($urandom);
      case (h % KIND_COUNT)
        KIND_TAKEN: b.taken = $urandom_range(19) != 0;
        KIND_NOT:   b.taken = $urandom_range(19) == 0;
        KIND_ALT:   b.taken = hot_visits[h][0];
        KIND_LOOP:  b.taken = hot_visits[h][1:0] != 2'd3;
        default:    b.taken = last_outcome;
      endcase
      hot_visits[h]++;
    end
    last_outcome = b.taken;
    return b;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_MODE:         mode_q      = val[1:0];
      CFG_CHOOSER_BITS: cho_bits_q  = val;
      CFG_GSHARE_BITS:  gsh_bits_q  = val;
      CFG_HISTORY_BITS: hist_bits_q = val;
      CFG_BIMODAL_BITS: bim_bits_q  = val;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_branches.size() != 0 || in_valid_i || n_checked != n_accepted);
  endtask

  // driver: predict on acceptance, then offer the next item or idle
  always @(posedge clk_i or negedge rst_ni) begin : drive_branches
    logic    fire;
    branch_t nxt;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      branch_pc_i <= '0;
      taken_i     <= 1'b0;
      n_accepted  <= 0;
    end else begin
      fire = in_valid_i && !in_stall_o;
      if (fire) begin
        expected_outcomes.push_back(resolve_branch(branch_pc_i, taken_i));
        n_accepted <= n_accepted + 1;
      end
      if (fire || !in_valid_i) begin
        if (pending_branches.size() != 0 && $urandom_range(99) >= send_idle_pct &&
            !(pending_branches[0].hold_for_drain && n_accepted + fire != n_checked)) begin
          nxt = pending_branches.pop_front();
          in_valid_i  <= 1'b1;
          branch_pc_i <= nxt.pc;
          taken_i     <= nxt.taken;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off once traffic is flowing
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      backlog_left <= 0;
      backlog_done <= 1'b0;
    end else if (backlog_left != 0) begin
      backlog_left <= backlog_left - 1;
    end else if (!backlog_done && n_accepted >= BACKLOG_AT) begin
      backlog_left <= BACKLOG_LEN;
      backlog_done <= 1'b1;
    end
  end

  // monitor: compare each accepted result with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin : check_results
    outcome_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      n_checked   <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_outcomes.size() == 0) begin
          $error("result with no branch outstanding");
          fail_count++;
        end else begin
          want = expected_outcomes.pop_front();
          if (predicted_taken_o !== want.predicted) begin
            $error("predicted_taken: expected %0d, got %0d", want.predicted, predicted_taken_o);
            fail_count++;
          end
          if (mispredicted_o !== want.miss) begin
            $error("mispredicted: expected %0d, got %0d", want.miss, mispredicted_o);
            fail_count++;
          end
          if (branches_seen_o !== want.branches) begin
            $error("branches_seen: expected %0d, got %0d", want.branches, branches_seen_o);
            fail_count++;
          end
          if (misses_seen_o !== want.misses) begin
            $error("misses_seen: expected %0d, got %0d", want.misses, misses_seen_o);
            fail_count++;
          end
        end
        n_checked <= n_checked + 1;
      end
      out_stall_i <= (backlog_left != 0) || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // run phases
  initial begin : run_phases
    branch_t b;
    reset_predictor();
    foreach (hot_pc[i]) begin
      hot_pc[i] = $urandom;
      hot_visits[i] = 0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clk_i);
      // idle profile: sender-light, then receiver-light, then none
      if (p < 3) begin
        send_idle_pct = 35;
        recv_idle_pct = 86;
      end else if (p < 6) begin
        send_idle_pct = 86;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p != 0) begin
        // mode data carries random upper bits, only the low two count
        write_reg(CFG_MODE, {2'($urandom_range(3)), PLAN_MODE[p]});
        write_reg(CFG_CHOOSER_BITS, PLAN_CHO[p]);
        write_reg(CFG_GSHARE_BITS, PLAN_GSH[p]);
        write_reg(CFG_HISTORY_BITS, PLAN_HIST[p]);
        write_reg(CFG_BIMODAL_BITS, PLAN_BIM[p]);
        @(negedge clk_i);
      end else begin
        // address extremes, ignored low bits, aliasing and same-entry runs
        queue_branch(32'h0000_0000, 1'b1);
        queue_branch(32'h0000_0000, 1'b1);
        queue_branch(32'h0000_0003, 1'b0);
        queue_branch(32'h0000_0001, 1'b0);
        queue_branch(32'h0000_0002, 1'b0);
        queue_branch(32'hFFFF_FFFF, 1'b0);
        queue_branch(32'hFFFF_FFFC, 1'b0);
        queue_branch(32'hFFFF_FFFD, 1'b1);
        queue_branch(32'h0001_0000, 1'b0);
        queue_branch(32'h0001_0000, 1'b1);
        queue_branch(32'hAAAA_AAAA, 1'b1);
        queue_branch(32'h5555_5555, 1'b0);
        for (int i = 0; i < 8; i++) queue_branch(32'h0000_1234, i[0]);
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        b = make_branch();
        if (p == DRAIN_PHASE && i == DRAIN_ITEM) b.hold_for_drain = 1'b1;
        pending_branches.push_back(b);
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // hang guard
  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
